// ===== src/mpqb_pkg.sv =====
// Package for the multilevel priority queue: types, codes and sizes.
// Used by the controller, the datapath and the top level.
package mpqb_pkg;

  localparam int NUM_QUEUES = 32;
  localparam int NUM_NODES  = 64;
  localparam int QW = 5;
  localparam int NW = 6;
  localparam int CW = 7;

  typedef enum logic [1:0] {
    REQ_ENQ   = 2'd0,
    REQ_REM   = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_RSVD  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_QUEUED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]    req_type;
    logic [QW-1:0] queue_num;
    logic [NW-1:0] node_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]    status;
    logic          head_valid;
    logic [NW-1:0] head_node;
    logic [CW-1:0] queue_count;
    logic [31:0]   nonempty_map;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EXEC  = 2'd1,
    S_OUT   = 2'd2
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic emit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic dummy;
  } dp_stat_t;

endpackage

// ===== src/mpqb_ctrl.sv =====
// Controller for the priority queue: sequences load, update and result.
// Depends on mpqb_pkg.
module mpqb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output mpqb_pkg::dp_cmd_t cmd,
  input  mpqb_pkg::dp_stat_t stat
);
  import mpqb_pkg::*;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_OUT;
      S_OUT:  if (!ov_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // the output register frees the front end while a result waits
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    ov_nxt   = ov_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_EXEC: cmd.exec = 1'b1;
      S_OUT: if (!ov_r || !out_stall) begin
        cmd.emit = 1'b1;
        ov_nxt   = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid = ov_r & ~stat.dummy;
endmodule

// ===== src/mpqb_dp.sv =====
// Datapath: link tables, per-queue head/tail/count, bitmap, output register.
// Depends on mpqb_pkg.
module mpqb_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  mpqb_pkg::in_item_t  in_data,
  output mpqb_pkg::out_item_t out_data,
  input  mpqb_pkg::dp_cmd_t   cmd,
  output mpqb_pkg::dp_stat_t  stat
);
  import mpqb_pkg::*;

  logic [NW-1:0] next_link [NUM_NODES];
  logic [NW-1:0] prev_link [NUM_NODES];
  logic [QW-1:0] node_owner [NUM_NODES];
  logic [NUM_NODES-1:0] queued_r;
  logic [NW-1:0] head_ptr [NUM_QUEUES];
  logic [NW-1:0] tail_ptr [NUM_QUEUES];
  logic [CW-1:0] count_r [NUM_QUEUES];
  logic [31:0]   map_r;

  in_item_t  req_r;
  // registered reads taken at load
  logic [NW-1:0] rd_next_r, rd_prev_r, rd_head_r, rd_tail_r;
  logic [QW-1:0] rd_owner_r;
  logic [CW-1:0] rd_cnt_r;
  logic          rd_q_r;
  status_t       st_r;
  out_item_t     out_r;

  logic [QW-1:0] q;
  logic [NW-1:0] n;
  logic          is_enq, is_rem, is_hd, is_tl;
  status_t       st_nxt;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r      <= in_data;
      rd_next_r  <= next_link[in_data.node_id];
      rd_prev_r  <= prev_link[in_data.node_id];
      rd_owner_r <= node_owner[in_data.node_id];
      rd_head_r  <= head_ptr[in_data.queue_num];
      rd_tail_r  <= tail_ptr[in_data.queue_num];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queued_r <= '0;
      map_r    <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) count_r[i] <= '0;
      rd_q_r   <= 1'b0;
      rd_cnt_r <= '0;
    end else begin
      if (cmd.load) begin
        rd_q_r   <= queued_r[in_data.node_id];
        rd_cnt_r <= count_r[in_data.queue_num];
      end
      if (cmd.exec && st_nxt == ST_OK) begin
        if (is_enq) begin
          queued_r[n]  <= 1'b1;
          count_r[q]   <= rd_cnt_r + CW'(1);
          map_r[q]     <= 1'b1;
        end else if (is_rem) begin
          queued_r[n]  <= 1'b0;
          count_r[q]   <= rd_cnt_r - CW'(1);
          if (rd_cnt_r == CW'(1)) map_r[q] <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    q      = req_r.queue_num;
    n      = req_r.node_id;
    is_enq = (req_r.req_type == REQ_ENQ);
    is_rem = (req_r.req_type == REQ_REM);
    is_hd  = (rd_head_r == n);
    is_tl  = (rd_tail_r == n);
    st_nxt = ST_OK;
    if (is_enq) begin
      if (rd_q_r) st_nxt = ST_QUEUED;
    end else if (is_rem) begin
      if (rd_cnt_r == '0) st_nxt = ST_EMPTY;
      else if (!rd_q_r || rd_owner_r != q) st_nxt = ST_ABSENT;
    end
  end

  // link-table writes
  always_ff @(posedge clk) begin
    if (cmd.exec && st_nxt == ST_OK) begin
      if (is_enq) begin
        if (rd_cnt_r == '0) begin
          head_ptr[q]  <= n;
          prev_link[n] <= '0;
        end else begin
          next_link[rd_tail_r] <= n;
          prev_link[n]         <= rd_tail_r;
        end
        next_link[n]  <= '0;
        tail_ptr[q]   <= n;
        node_owner[n] <= q;
      end else if (is_rem) begin
        if (is_hd) head_ptr[q] <= rd_next_r;
        else       next_link[rd_prev_r] <= rd_next_r;
        if (is_tl) tail_ptr[q] <= rd_prev_r;
        else       prev_link[rd_next_r] <= rd_prev_r;
      end
    end
    if (cmd.exec) st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.status       <= st_r;
      out_r.head_valid   <= (count_r[q] != '0);
      out_r.head_node    <= (count_r[q] != '0) ? head_ptr[q] : '0;
      out_r.queue_count  <= count_r[q];
      out_r.nonempty_map <= map_r;
    end
  end

  assign out_data   = out_r;
  assign stat.dummy = 1'b0;
endmodule

// ===== src/multilevel_priority_queue_bitmap.sv =====
// Multilevel priority ready queue with non-empty bitmap.
// Each item goes through table read, link update and result register in turn.
// Items are taken one at a time; a stalled result lets the next item be
// taken and updated, which then waits to load the output register.
// out_valid rises when the result register is loaded, after the link update.
// Reset clears all queue counts, queued flags and the bitmap at once.
// Depends on mpqb_pkg, mpqb_ctrl and mpqb_dp.
module multilevel_priority_queue_bitmap (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mpqb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mpqb_pkg::out_item_t out_data
);
  import mpqb_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mpqb_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .cmd, .stat
  );

  mpqb_dp u_dp (
    .clk, .rst_n, .in_data, .out_data, .cmd, .stat
  );
endmodule
